/* rtl/core/lzw12_pkg.sv */
// Shared constants and types of the 12-bit LZW encoder.
package lzw12_pkg;

  localparam int HASH_SLOTS_DEF = 8192;
  localparam int CODE_BITS_DEF  = 12;
  localparam int CAP_W          = 24;
  localparam int HASH_MULT      = 31;
  localparam int HASH_MOD       = 5381;
  localparam int FIRST_CODE     = 256;
  localparam int MAX_RES        = 4;
  // floor(2^32 / HASH_MOD): reciprocal used for the hash remainder
  localparam longint HASH_RECIP = (64'd1 << 32) / HASH_MOD;
  localparam int RECIP_W        = 20;
  localparam int REM_W          = 14;
  localparam int PEND_W         = 7;
  localparam int CNT_W          = 5;
  localparam int RES_W          = 3;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH1,
    ST_HASH2,
    ST_HASH3,
    ST_READ,
    ST_CHECK,
    ST_CAP,
    ST_EMIT,
    ST_PAD
  } lzw_state_t;

endpackage

/* rtl/core/lzw12_dict.sv */
// Dictionary slot memory: one write port, one registered read port.
module lzw12_dict #(
  parameter int ADDR_W  = 13,
  parameter int ENTRY_W = 33
) (
  input  logic               clk,
  input  logic               rd_en,
  input  logic [ADDR_W-1:0]  rd_addr,
  output logic [ENTRY_W-1:0] rd_data,
  input  logic               wr_en,
  input  logic [ADDR_W-1:0]  wr_addr,
  input  logic [ENTRY_W-1:0] wr_data
);

  logic [ENTRY_W-1:0] mem [(1 << ADDR_W)];

  // write slot
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read slot, registered data in the next cycle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/core/lzw_encoder_12bit_top.sv */
// LZW encoder with hashed dictionary and MSB-first code packing.
//
//  channel | dir | transfer moves
//  in_     | in  | tdata[7:0] in_byte, tlast is_last
//  out_    | out | tdata[7:0] out_byte, tlast last, tuser[0] overflow
//  cfg_    | in  | data[23:0] body_capacity
//
// One byte at a time. A byte that hits passes accept, three hash steps, memory read
// and compare; each further probe of the linear chain adds a read and a compare (one read port).
// Emitting a code adds a capacity check and the emit steps that push its packed output bytes;
// the stream end emits the final code the same way and, if bits remain, a pad byte.
// After reset and after each stream end a clearing pass writes every slot,
// during which no byte is taken (cfg writes are taken).
// Output stalls hold the emit sequencer; the output register frees in_ from
// the out_ side once the last result of a byte is in it.
module lzw_encoder_12bit_top #(
  parameter int HASH_SLOTS = lzw12_pkg::HASH_SLOTS_DEF,
  parameter int CODE_BITS  = lzw12_pkg::CODE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic        out_tlast,
  output logic [0:0]  out_tuser,  // [0] overflow
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_data
);
  import lzw12_pkg::*;

  localparam int ABITS   = $clog2(HASH_SLOTS);
  localparam int VW      = CODE_BITS + 6;
  localparam int PROD_W  = VW + RECIP_W;
  localparam int ACC_W   = PEND_W + CODE_BITS;
  localparam int ENTRY_W = 1 + CODE_BITS + 8 + CODE_BITS;
  localparam int NF_W    = CODE_BITS + 1;

  lzw_state_t state_r, state_nxt;

  logic [7:0]           c_r, c_nxt;
  logic                 last_r, last_nxt;
  logic                 open_r, open_nxt;
  logic                 drop_r, drop_nxt;
  logic [CODE_BITS-1:0] prefix_r, prefix_nxt;
  logic [NF_W-1:0]      nfree_r, nfree_nxt;
  logic [PEND_W-1:0]    pend_r, pend_nxt;
  logic [2:0]           pc_r, pc_nxt;
  logic [CAP_W-1:0]     bemit_r, bemit_nxt;
  logic [CAP_W-1:0]     cap_r;
  logic [PROD_W-1:0]    prod_r, prod_nxt;
  logic [REM_W-1:0]     rem_r, rem_nxt;
  logic [ABITS-1:0]     addr_r, addr_nxt;
  logic [ABITS-1:0]     probe_r, probe_nxt;
  logic [ABITS-1:0]     clr_r, clr_nxt;
  logic                 fin_r, fin_nxt;
  logic                 ins_r, ins_nxt;
  logic [ACC_W-1:0]     acc_r, acc_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [RES_W-1:0]     res_r, res_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [7:0]           out_data_r, out_data_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 out_ovf_r, out_ovf_nxt;

  logic                 in_acc, can_push, push, push_last, push_ovf;
  logic [7:0]           push_data;
  logic [VW-1:0]        hv;
  logic [VW-1:0]        hq;
  logic [REM_W-1:0]     hmod;
  logic [ENTRY_W-1:0]   rd_data, wr_data;
  logic                 rd_en, wr_en;
  logic [ABITS-1:0]     wr_addr;
  logic                 rd_vld, hit, probe_end, emit_more, cap_fail, do_ins, room;
  logic [CODE_BITS-1:0] rd_prefix, rd_code;
  logic [7:0]           rd_byte;
  logic [CAP_W:0]       need;
  logic [CNT_W-1:0]     add_bytes;
  logic [CAP_W-1:0]     bemit_inc;

  // dictionary memory
  lzw12_dict #(.ADDR_W(ABITS), .ENTRY_W(ENTRY_W)) u_dict (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (addr_r),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // shared conditions
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign can_push  = !out_valid_r || out_tready;

  assign hv   = VW'({prefix_r, 5'b0}) - VW'(prefix_r) + VW'(c_r);
  assign hq   = VW'(prod_r >> 32);
  assign hmod = (rem_r >= REM_W'(HASH_MOD)) ? rem_r - REM_W'(HASH_MOD) : rem_r;

  assign rd_vld    = rd_data[ENTRY_W-1];
  assign rd_prefix = rd_data[ENTRY_W-2 -: CODE_BITS];
  assign rd_byte   = rd_data[CODE_BITS+7 -: 8];
  assign rd_code   = rd_data[CODE_BITS-1:0];
  assign hit       = rd_vld && (rd_prefix == prefix_r) && (rd_byte == c_r);
  assign probe_end = (probe_r == ABITS'(HASH_SLOTS - 1));

  assign add_bytes = (CNT_W'(pc_r) + CNT_W'(CODE_BITS) + CNT_W'(7)) >> 3;
  assign need      = {1'b0, bemit_r} + (CAP_W+1)'(add_bytes);
  assign cap_fail  = need > {1'b0, cap_r};
  assign emit_more = cnt_r >= CNT_W'(8);
  assign room      = nfree_r < NF_W'(1 << CODE_BITS);
  assign do_ins    = (state_r == ST_CAP) && !cap_fail && !fin_r && ins_r && room;
  assign bemit_inc = (bemit_r == {CAP_W{1'b1}}) ? bemit_r : bemit_r + CAP_W'(1);

  // memory port control
  assign rd_en   = (state_r == ST_READ);
  assign wr_en   = (state_r == ST_CLEAR) || do_ins;
  assign wr_addr = (state_r == ST_CLEAR) ? clr_r : addr_r;
  assign wr_data = (state_r == ST_CLEAR) ? '0
                 : {1'b1, prefix_r, c_r, nfree_r[CODE_BITS-1:0]};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_r == ABITS'(HASH_SLOTS - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (drop_r) state_nxt = in_tlast ? ST_CLEAR : ST_IDLE;
          else if (!open_r) state_nxt = in_tlast ? ST_CAP : ST_IDLE;
          else state_nxt = ST_HASH1;
        end
      end
      ST_HASH1: state_nxt = ST_HASH2;
      ST_HASH2: state_nxt = ST_HASH3;
      ST_HASH3: state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (!rd_vld) state_nxt = ST_CAP;
        else if (hit) state_nxt = last_r ? ST_CAP : ST_IDLE;
        else if (probe_end) state_nxt = ST_CAP;
        else state_nxt = ST_READ;
      end
      ST_CAP: begin
        if (cap_fail) begin
          if (can_push) state_nxt = last_r ? ST_CLEAR : ST_IDLE;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!emit_more) begin
          if (fin_r) state_nxt = (cnt_r != '0) ? ST_PAD : ST_CLEAR;
          else state_nxt = last_r ? ST_CAP : ST_IDLE;
        end
      end
      ST_PAD: begin
        if (can_push) state_nxt = ST_CLEAR;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // datapath and result generation
  always_comb begin
    c_nxt      = c_r;
    last_nxt   = last_r;
    open_nxt   = open_r;
    drop_nxt   = drop_r;
    prefix_nxt = prefix_r;
    nfree_nxt  = nfree_r;
    pend_nxt   = pend_r;
    pc_nxt     = pc_r;
    bemit_nxt  = bemit_r;
    prod_nxt   = prod_r;
    rem_nxt    = rem_r;
    addr_nxt   = addr_r;
    probe_nxt  = probe_r;
    clr_nxt    = '0;
    fin_nxt    = fin_r;
    ins_nxt    = ins_r;
    acc_nxt    = acc_r;
    cnt_nxt    = cnt_r;
    res_nxt    = res_r;
    push       = 1'b0;
    push_data  = '0;
    push_last  = 1'b0;
    push_ovf   = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        // sweep slots and drop all stream state
        clr_nxt    = clr_r + ABITS'(1);
        open_nxt   = 1'b0;
        drop_nxt   = 1'b0;
        prefix_nxt = '0;
        nfree_nxt  = NF_W'(FIRST_CODE);
        pend_nxt   = '0;
        pc_nxt     = '0;
        bemit_nxt  = '0;
      end
      ST_IDLE: begin
        if (in_acc) begin
          c_nxt    = in_tdata;
          last_nxt = in_tlast;
          res_nxt  = '0;
          fin_nxt  = 1'b0;
          if (!drop_r && !open_r) begin
            open_nxt   = 1'b1;
            prefix_nxt = CODE_BITS'(in_tdata);
            fin_nxt    = in_tlast;
          end
        end
      end
      ST_HASH1: prod_nxt = PROD_W'(hv) * PROD_W'(HASH_RECIP);
      ST_HASH2: rem_nxt  = REM_W'(hv - VW'(hq * VW'(HASH_MOD)));
      ST_HASH3: begin
        addr_nxt  = ABITS'(hmod);
        probe_nxt = '0;
      end
      ST_CHECK: begin
        if (!rd_vld) begin
          ins_nxt = 1'b1;
        end else if (hit) begin
          prefix_nxt = rd_code;
          fin_nxt    = last_r;
        end else if (probe_end) begin
          ins_nxt = 1'b0;
        end else begin
          addr_nxt  = addr_r + ABITS'(1);
          probe_nxt = probe_r + ABITS'(1);
        end
      end
      ST_CAP: begin
        if (cap_fail) begin
          // overflow result, then close or drop the stream
          if (can_push) begin
            push      = (res_r < RES_W'(MAX_RES));
            push_last = 1'b1;
            push_ovf  = 1'b1;
            if (!last_r) drop_nxt = 1'b1;
          end
        end else begin
          acc_nxt = {pend_r, prefix_r};
          cnt_nxt = CNT_W'(pc_r) + CNT_W'(CODE_BITS);
          if (!fin_r) begin
            if (do_ins) nfree_nxt = nfree_r + NF_W'(1);
            prefix_nxt = CODE_BITS'(c_r);
          end
        end
      end
      ST_EMIT: begin
        if (emit_more) begin
          if (can_push) begin
            push      = (res_r < RES_W'(MAX_RES));
            push_data = 8'(acc_r >> (cnt_r - CNT_W'(8)));
            push_last = fin_r && ((cnt_r == CNT_W'(8)) || (res_r == RES_W'(MAX_RES - 1)));
            if (res_r < RES_W'(MAX_RES)) res_nxt = res_r + RES_W'(1);
            bemit_nxt = bemit_inc;
            cnt_nxt   = cnt_r - CNT_W'(8);
          end
        end else begin
          // keep leftover bits for the next code
          pend_nxt = PEND_W'(acc_r) & ((PEND_W'(1) << cnt_r) - PEND_W'(1));
          pc_nxt   = cnt_r[2:0];
          if (!fin_r && last_r) fin_nxt = 1'b1;
        end
      end
      ST_PAD: begin
        if (can_push) begin
          push      = (res_r < RES_W'(MAX_RES));
          push_data = 8'({1'b0, pend_r} << (4'd8 - {1'b0, pc_r}));
          push_last = 1'b1;
          bemit_nxt = bemit_inc;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    if (push) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = push_data;
      out_last_nxt  = push_last;
      out_ovf_nxt   = push_ovf;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tlast    = out_last_r;
  assign out_tuser[0] = out_ovf_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      open_r      <= 1'b0;
      drop_r      <= 1'b0;
      fin_r       <= 1'b0;
      ins_r       <= 1'b0;
      res_r       <= '0;
      nfree_r     <= NF_W'(FIRST_CODE);
      pc_r        <= '0;
      pend_r      <= '0;
      prefix_r    <= '0;
      bemit_r     <= '0;
      cnt_r       <= '0;
      cap_r       <= {CAP_W{1'b1}};
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      open_r      <= open_nxt;
      drop_r      <= drop_nxt;
      fin_r       <= fin_nxt;
      ins_r       <= ins_nxt;
      res_r       <= res_nxt;
      nfree_r     <= nfree_nxt;
      pc_r        <= pc_nxt;
      pend_r      <= pend_nxt;
      prefix_r    <= prefix_nxt;
      bemit_r     <= bemit_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) cap_r <= cfg_data;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    c_r        <= c_nxt;
    last_r     <= last_nxt;
    prod_r     <= prod_nxt;
    rem_r      <= rem_nxt;
    addr_r     <= addr_nxt;
    probe_r    <= probe_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  // an overflow result always closes the stream's output
  a_ovf_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast)
    else $error("overflow result without last");

  // code numbers never pass the code space
  a_nfree: assert property (@(posedge clk) disable iff (!rst_n)
    nfree_r <= NF_W'(1 << CODE_BITS))
    else $error("next free code beyond limit");

  // no dictionary insert while clearing or idle
  a_ins: assert property (@(posedge clk) disable iff (!rst_n)
    do_ins |-> (state_r == ST_CAP) && !in_tready)
    else $error("dictionary insert outside capacity step");

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench of the 12-bit LZW encoder: stream traffic, capacity phases, scoreboard.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lzw12_pkg::*;

  localparam int CODE_LIMIT = 1 << CODE_BITS_DEF;
  localparam logic [23:0] CAP_MAX = 24'hFFFFFF;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       last;
    logic       overflow;
  } packed_out_t;

  // Tracks the encoder state and the packed bytes each transfer should produce.
  class lzw_scoreboard;
    bit          used[HASH_SLOTS_DEF];
    bit [11:0]   key_prefix[HASH_SLOTS_DEF];
    bit [7:0]    key_chr[HASH_SLOTS_DEF];
    bit [11:0]   code_of[HASH_SLOTS_DEF];
    bit          open_stream, dropping;
    bit [11:0]   prefix;
    int unsigned free_code, pend_bits, pend_cnt, body_bytes, step_n;
    bit [23:0]   capacity;
    packed_out_t byte_queue[$];
    int          errors, results, overflows, streams;

    function void clear_stream();
      foreach (used[i]) used[i] = 0;
      open_stream = 0;
      dropping    = 0;
      prefix      = 0;
      free_code   = FIRST_CODE;
      pend_bits   = 0;
      pend_cnt    = 0;
      body_bytes  = 0;
    endfunction

    function void reset_all();
      clear_stream();
      capacity = CAP_MAX;
    endfunction

    function int unsigned probe_start(int unsigned p, int unsigned c);
      return ((p * HASH_MULT + c) % HASH_MOD) % HASH_SLOTS_DEF;
    endfunction

    function void push(int unsigned b, bit l, bit o);
      packed_out_t r;
      if (step_n >= MAX_RES) return;
      r.code_byte = b[7:0];
      r.last      = l;
      r.overflow  = o;
      byte_queue.push_back(r);
      step_n++;
    endfunction

    // Pack one code MSB-first; refuse it if the body would outgrow capacity.
    function bit append_code(int unsigned code);
      longint unsigned total;
      int unsigned acc, cnt;
      total = longint'(body_bytes) * 8 + pend_cnt + CODE_BITS_DEF;
      if ((total + 7) / 8 > capacity) return 0;
      acc = (pend_bits << CODE_BITS_DEF) | (code & (CODE_LIMIT - 1));
      cnt = pend_cnt + CODE_BITS_DEF;
      while (cnt >= 8) begin
        push(acc >> (cnt - 8), 0, 0);
        if (body_bytes < CAP_MAX) body_bytes++;
        cnt -= 8;
      end
      pend_cnt  = cnt;
      pend_bits = acc & ((1 << cnt) - 1);
      return 1;
    endfunction

    function bit close_body();
      if (!append_code(prefix)) return 0;
      if (pend_cnt > 0) begin
        push(pend_bits << (8 - pend_cnt), 0, 0);
        if (body_bytes < CAP_MAX) body_bytes++;
      end
      if (step_n > 0) byte_queue[$].last = 1;
      return 1;
    endfunction

    // Note one accepted input transfer and queue what it produces.
    function void note_input(logic [7:0] c, logic is_last);
      int unsigned h, idx, n;
      bit hit;
      step_n = 0;
      if (is_last) streams++;
      if (dropping) begin
        if (is_last) clear_stream();
        return;
      end
      if (!open_stream) begin
        open_stream = 1;
        prefix = c;
      end else begin
        hit = 0;
        h = probe_start(prefix, c);
        for (n = 0; n < HASH_SLOTS_DEF; n++) begin
          idx = (h + n) % HASH_SLOTS_DEF;
          if (!used[idx]) break;
          if (key_prefix[idx] == prefix && key_chr[idx] == c) begin
            hit = 1;
            break;
          end
        end
        if (hit) begin
          prefix = code_of[idx];
        end else begin
          if (!append_code(prefix)) begin
            push(0, 1, 1);
            overflows++;
            if (is_last) clear_stream();
            else dropping = 1;
            return;
          end
          // Insert at the empty slot the probe stopped on, if any.
          if (free_code < CODE_LIMIT && n < HASH_SLOTS_DEF) begin
            used[idx]       = 1;
            key_prefix[idx] = prefix;
            key_chr[idx]    = c;
            code_of[idx]    = free_code[11:0];
            free_code++;
          end
          prefix = c;
        end
      end
      if (is_last) begin
        if (!close_body()) begin
          push(0, 1, 1);
          overflows++;
        end
        clear_stream();
      end
    endfunction

    // Compare one result transfer with the oldest expectation.
    function void check_result(logic [7:0] b, logic l, logic o);
      packed_out_t e;
      results++;
      if (byte_queue.size() == 0) begin
        $error("unexpected result: out_byte=%0h last=%0b overflow=%0b", b, l, o);
        errors++;
        return;
      end
      e = byte_queue.pop_front();
      if (b !== e.code_byte) begin
        $error("out_byte: expected %0h, got %0h", e.code_byte, b);
        errors++;
      end
      if (l !== e.last) begin
        $error("last: expected %0b, got %0b", e.last, l);
        errors++;
      end
      if (o !== e.overflow) begin
        $error("overflow: expected %0b, got %0b", e.overflow, o);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0, in_tlast = 0;
  logic [7:0]  in_tdata = '0;
  logic        in_tready;
  logic        out_tvalid, out_tlast, out_tready = 0;
  logic [7:0]  out_tdata;
  logic [0:0]  out_tuser;
  logic        cfg_valid = 0, cfg_ready;
  logic [23:0] cfg_data = '0;

  lzw_encoder_12bit_top i_dut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast, .out_tuser,
    .cfg_valid, .cfg_ready, .cfg_data
  );

  lzw_scoreboard sb = new();
  int sent_items = 0;
  bit hold_done = 0;

  always #10 clk = ~clk;

  // Result side: random backpressure, one long hold-off, one calm window.
  int hold_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        sb.check_result(out_tdata, out_tlast, out_tuser[0]);
        if (sb.results == 60 && !hold_done) begin
          hold_left = 400;
          hold_done = 1;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 0;
      end else if (sb.results >= 150 && sb.results < 300) begin
        out_tready <= 1;
      end else begin
        out_tready <= ($urandom_range(99) >= 15);
      end
    end
  end

  // Offer one byte, with an occasional gap, and wait for the transfer.
  task automatic send_byte(input logic [7:0] b, input logic l);
    int gap;
    gap = 0;
    if (!(sent_items >= 200 && sent_items < 300) && $urandom_range(99) < 15)
      gap = $urandom_range(1, 5);
    repeat (gap) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata  <= b;
    in_tlast  <= l;
    do @(posedge clk); while (!in_tready);
    sb.note_input(b, l);
    sent_items++;
  endtask

  // Hold the input until every expected byte has left, then let the pipe drain.
  task automatic drain();
    in_tvalid <= 0;
    do @(posedge clk); while (sb.byte_queue.size() != 0);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [23:0] v);
    drain();
    cfg_valid <= 1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    sb.capacity = v;
  endtask

  task automatic send_stream(input logic [7:0] s[]);
    foreach (s[i]) send_byte(s[i], i == s.size() - 1);
  endtask

  // Random stream; narrow alphabets give dictionary hits.
  task automatic random_stream(input int len);
    int alpha;
    alpha = ($urandom_range(1) != 0) ? 256 : $urandom_range(1, 4);
    for (int i = 0; i < len; i++) begin
      if (alpha == 256) send_byte(8'($urandom_range(255)), i == len - 1);
      else send_byte(8'(8'h41 + $urandom_range(alpha - 1)), i == len - 1);
    end
  endtask

  initial begin
    int pick;
    sb.reset_all();
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: single bytes at the extremes, repeats, alternation.
    send_stream('{8'h00});
    send_stream('{8'hFF});
    send_stream('{8'h41, 8'h41, 8'h41, 8'h41, 8'h41});
    send_stream('{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF});
    // Capacity limits: overflow on the first code, mid-stream, at the close, exact fit.
    write_capacity(24'd0);
    send_stream('{8'h05});
    send_stream('{8'h01, 8'h02, 8'h03});
    write_capacity(24'd2);
    send_stream('{8'h01, 8'h02, 8'h03});
    write_capacity(24'd3);
    send_stream('{8'h01, 8'h02});
    write_capacity(24'd4);
    send_stream('{8'h01, 8'h02});
    write_capacity(CAP_MAX);

    // Long stream that builds a deep dictionary with long probe chains.
    random_stream(150);

    // Random streams under a mix of capacities.
    while (sent_items < 420) begin
      drain();
      pick = $urandom_range(9);
      if (pick < 5) write_capacity(CAP_MAX);
      else if (pick < 8) write_capacity(24'($urandom_range(0, 40)));
      else write_capacity(24'($urandom_range(0, 24'hFFFFFF)));
      random_stream($urandom_range(1, 30));
    end

    drain();
    $display("Covered %0d streams, %0d input bytes, %0d result bytes, %0d overflow results.",
             sb.streams, sent_items, sb.results, sb.overflows);
    if (sb.errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #100ms;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
